### design/dtwlb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtwlb_pkg
// Shared types, widths and codes of the LB_Petitjean lower-bound core.
// ----------------------------------------------------------------------------
package dtwlb_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int BOUND_BITS    = 48;
	localparam int DIST_BITS     = 2 * SAMPLE_BITS;
	localparam int POS_BITS      = 12;
	localparam int WHW_BITS      = 6;
	localparam int LEN_BITS      = 13;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 48;
	localparam int W_MAX_DEF     = 32;
	localparam int LEN_MAX_DEF   = 4096;
	localparam int EDGE          = 3;
	localparam int M_MIN         = 2 * EDGE + 1;
	localparam int OUT_LD_BITS   = 32;

	localparam logic [BOUND_BITS-1:0] BOUND_MAX = '1;
	localparam logic [LEN_BITS-1:0]   LEN_RESET = LEN_BITS'(64);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW    = 2'd0,
		CFG_SEQ_LEN   = 2'd1,
		CFG_THRESHOLD = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STAT_RUNNING   = 2'd0,
		STAT_FINISHED  = 2'd1,
		STAT_ABANDONED = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_PUSH,
		CELL_ROT
	} cell_op_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_ISSUE,
		FSM_WAIT,
		FSM_OUT
	} fsm_state_t;

	typedef struct packed {
		logic                  first;
		logic [BOUND_BITS-1:0] initial_bound;
		sample_t               query_sample;
		sample_t               ref_env_upper;
		sample_t               ref_env_lower;
		sample_t               ref_sample;
		sample_t               query_env_upper;
		sample_t               query_env_lower;
	} in_item_t;

	typedef struct packed {
		logic [POS_BITS-1:0]    position;
		sample_t                proj_upper;
		sample_t                proj_lower;
		logic [OUT_LD_BITS-1:0] dist_incr;
		logic [BOUND_BITS-1:0]  running_bound;
		status_t                status;
		logic                   last;
	} out_item_t;

	typedef struct packed {
		logic    start;
		logic    in_range;
		sample_t x;
		sample_t up;
		sample_t lp;
		sample_t uq;
		sample_t lq;
	} dist_req_t;

	typedef struct packed {
		logic                 valid;
		logic [DIST_BITS-1:0] ld;
	} dist_rsp_t;

endpackage
`default_nettype wire

### design/dtwlb_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtwlb_cell
// One sample cell of the clamped-query ring: hold, shift in, or rotate.
// ----------------------------------------------------------------------------
module dtwlb_cell (
	input  logic                clk,
	input  dtwlb_pkg::cell_op_t op,
	input  dtwlb_pkg::sample_t  push_in,
	input  dtwlb_pkg::sample_t  rot_in,
	output dtwlb_pkg::sample_t  val
);
	import dtwlb_pkg::*;

	sample_t val_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_PUSH: val_q <= push_in;
			CELL_ROT:  val_q <= rot_in;
			default:   val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule
`default_nettype wire

### design/dtwlb_dist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtwlb_dist
// Three-stage four-case squared-distance increment of the lower bound.
// ----------------------------------------------------------------------------
module dtwlb_dist (
	input  logic                clk,
	input  logic                arst_n,
	input  dtwlb_pkg::dist_req_t req,
	output dtwlb_pkg::dist_rsp_t rsp
);
	import dtwlb_pkg::*;

	typedef logic signed [SAMPLE_BITS:0] diff_t;

	function automatic logic [SAMPLE_BITS-1:0] mag(input diff_t d);
		diff_t n;
		n = (d < 0) ? -d : d;
		return n[SAMPLE_BITS-1:0];
	endfunction

	diff_t x_e, up_e, lp_e, uq_e, lq_e, d0, d1;

	logic [SAMPLE_BITS-1:0] m0_s1, m1_s1;
	logic                   v_s1;
	logic [DIST_BITS-1:0]   sq0_s2, sq1_s2;
	logic                   v_s2;
	logic [DIST_BITS-1:0]   ld_s3;
	logic                   v_s3;

	assign x_e  = diff_t'(req.x);
	assign up_e = diff_t'(req.up);
	assign lp_e = diff_t'(req.lp);
	assign uq_e = diff_t'(req.uq);
	assign lq_e = diff_t'(req.lq);

	// pick the two differences; the second is zero in the plain cases
	always_comb begin
		d0 = '0;
		d1 = '0;
		if (req.in_range) begin
			if (x_e > up_e && up_e > uq_e) begin
				d0 = x_e - uq_e;
				d1 = up_e - uq_e;
			end else if (x_e < lp_e && lp_e < lq_e) begin
				d0 = x_e - lq_e;
				d1 = lp_e - lq_e;
			end else if (x_e > up_e) begin
				d0 = x_e - up_e;
			end else if (x_e < lp_e) begin
				d0 = x_e - lp_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req.start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		m0_s1  <= mag(d0);
		m1_s1  <= mag(d1);
		sq0_s2 <= DIST_BITS'(m0_s1) * DIST_BITS'(m0_s1);
		sq1_s2 <= DIST_BITS'(m1_s1) * DIST_BITS'(m1_s1);
		ld_s3  <= (sq0_s2 > sq1_s2) ? sq0_s2 - sq1_s2 : '0;
	end

	assign rsp.valid = v_s3;
	assign rsp.ld    = ld_s3;

endmodule
`default_nettype wire

### design/dtw_lower_bound_petitjean_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dtw_lower_bound_petitjean_core
// Streaming LB_Petitjean lower bound for dynamic time warping.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   config  | cfg_we, cfg_idx, cfg_wdata       | in
//   input   | in_valid, in_stall, in_data      | in / stall out
//   result  | out_valid, out_stall, out_data   | out / stall in
//
// An item that emits nothing is taken without leaving the idle state. Each
// result rotates the clamped-sample ring of cells past the min/max compare,
// then passes the distance pipeline and the output register; the last item
// of a sequence emits up to w+1 results. Reset is asynchronous and needs no
// clearing pass. in_stall is high while an item is being worked on; a held
// result stalls the block.
// ----------------------------------------------------------------------------
module dtw_lower_bound_petitjean_core #(
	parameter int W_MAX   = dtwlb_pkg::W_MAX_DEF,
	parameter int LEN_MAX = dtwlb_pkg::LEN_MAX_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dtwlb_pkg::CFG_IDX_BITS-1:0]   cfg_idx,
	input  logic [dtwlb_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  dtwlb_pkg::in_item_t                  in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output dtwlb_pkg::out_item_t                 out_data
);
	import dtwlb_pkg::*;

	localparam int D    = 2 * W_MAX + 1;
	localparam int AW   = $clog2(D);
	localparam int TW   = $clog2(LEN_MAX + 2 * W_MAX + 2);
	localparam int DIW  = (W_MAX > 1) ? $clog2(W_MAX) : 1;
	localparam int SUMW = BOUND_BITS + 1;

	// configuration
	logic [WHW_BITS-1:0]   w_cfg_q;
	logic [LEN_BITS-1:0]   len_cfg_q;
	logic [BOUND_BITS-1:0] thr_q;
	logic [TW-1:0]         w_t, m_t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_cfg_q   <= '0;
			len_cfg_q <= LEN_RESET;
			thr_q     <= BOUND_MAX;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WINDOW:    w_cfg_q   <= cfg_wdata[WHW_BITS-1:0];
				CFG_SEQ_LEN:   len_cfg_q <= cfg_wdata[LEN_BITS-1:0];
				CFG_THRESHOLD: thr_q     <= cfg_wdata[BOUND_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (int'(w_cfg_q) > W_MAX) w_t = TW'(W_MAX);
		else w_t = TW'(w_cfg_q);
		if (int'(len_cfg_q) < M_MIN) m_t = TW'(M_MIN);
		else if (int'(len_cfg_q) > LEN_MAX) m_t = TW'(LEN_MAX);
		else m_t = TW'(len_cfg_q);
	end

	// control and payload state
	fsm_state_t            state_q, state_d;
	logic [TW-1:0]         pos_q, t_q, ii_q, ii_end_q;
	logic [BOUND_BITS-1:0] bound_q;
	logic                  abandoned_q, over_q;
	logic [AW-1:0]         r_q;
	logic                  have_q;
	sample_t               up_q, lp_q, cur_x_q, cur_uq_q, cur_lq_q;
	out_item_t             out_q;
	logic                  out_valid_q;
	sample_t               dl_x_q  [W_MAX];
	sample_t               dl_uq_q [W_MAX];
	sample_t               dl_lq_q [W_MAX];

	// input side
	logic          acc, take, emit_last, emit, item_done, push_dl_acc;
	logic [TW-1:0] t_new, ii_start, ii_end;
	sample_t       p_clamp;

	assign acc  = in_valid && (state_q == FSM_IDLE);
	assign take = acc && (in_data.first || (!abandoned_q && pos_q < m_t));
	assign t_new = in_data.first ? '0 : pos_q;

	always_comb begin
		p_clamp = in_data.query_sample;
		if (t_new >= TW'(EDGE) && t_new < m_t - TW'(EDGE)) begin
			if (in_data.query_sample > in_data.ref_env_upper)
				p_clamp = in_data.ref_env_upper;
			else if (in_data.query_sample < in_data.ref_env_lower)
				p_clamp = in_data.ref_env_lower;
		end
	end

	assign emit_last = (t_new == m_t - TW'(1));
	assign emit      = emit_last || (t_new >= w_t);
	assign ii_start  = (t_new >= w_t) ? t_new - w_t : '0;
	assign ii_end    = emit_last ? t_new : t_new - w_t;
	assign push_dl_acc = take && !emit;

	// ring of clamped samples: cell k holds the sample of age k
	cell_op_t ring_op;
	sample_t  ring_val [D];

	for (genvar k = 0; k < D; k++) begin : g_ring
		dtwlb_cell u_cell (
			.clk     (clk),
			.op      (ring_op),
			.push_in ((k == 0) ? p_clamp : ring_val[(k + D - 1) % D]),
			.rot_in  (ring_val[(k + 1) % D]),
			.val     (ring_val[k])
		);
	end

	// window ages of the current result
	logic [TW-1:0] a_pos, b_pos, dsel;
	logic [AW-1:0] lo_age, hi_age;
	logic          in_win, in_range;
	sample_t       x_sel, uq_sel, lq_sel, v0;

	always_comb begin
		a_pos  = (ii_q >= w_t) ? ii_q - w_t : '0;
		b_pos  = (ii_q + w_t < t_q) ? ii_q + w_t : t_q;
		lo_age = AW'(t_q - b_pos);
		hi_age = AW'(t_q - a_pos);
		dsel   = t_q - ii_q - TW'(1);
		if (ii_q == t_q) begin
			x_sel  = cur_x_q;
			uq_sel = cur_uq_q;
			lq_sel = cur_lq_q;
		end else begin
			x_sel  = dl_x_q[dsel[DIW-1:0]];
			uq_sel = dl_uq_q[dsel[DIW-1:0]];
			lq_sel = dl_lq_q[dsel[DIW-1:0]];
		end
	end

	assign v0       = ring_val[0];
	assign in_win   = (r_q >= lo_age) && (r_q <= hi_age);
	assign in_range = (ii_q >= TW'(EDGE)) && (ii_q < m_t - TW'(EDGE));

	// distance unit
	dist_req_t dreq;
	dist_rsp_t drsp;

	assign dreq.start    = (state_q == FSM_ISSUE);
	assign dreq.in_range = in_range;
	assign dreq.x        = x_sel;
	assign dreq.up       = up_q;
	assign dreq.lp       = lp_q;
	assign dreq.uq       = uq_sel;
	assign dreq.lq       = lq_sel;

	dtwlb_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// accumulate
	logic [SUMW-1:0]       sum;
	logic [BOUND_BITS-1:0] nb, bound_out;
	logic                  over;

	always_comb begin
		sum       = SUMW'(bound_q) + SUMW'(drsp.ld);
		nb        = sum[BOUND_BITS] ? BOUND_MAX : sum[BOUND_BITS-1:0];
		bound_out = in_range ? nb : bound_q;
		over      = in_range && (nb > thr_q);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= FSM_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		ring_op   = CELL_HOLD;
		item_done = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				if (take) begin
					ring_op = CELL_PUSH;
					if (emit) state_d = FSM_SCAN;
				end
			end
			FSM_SCAN: begin
				ring_op = CELL_ROT;
				if (r_q == AW'(D - 1)) state_d = FSM_ISSUE;
			end
			FSM_ISSUE: state_d = FSM_WAIT;
			FSM_WAIT: begin
				if (drsp.valid) state_d = FSM_OUT;
			end
			FSM_OUT: begin
				if (!out_stall) begin
					if (over_q || ii_q == ii_end_q) begin
						item_done = 1'b1;
						state_d   = FSM_IDLE;
					end else begin
						state_d = FSM_SCAN;
					end
				end
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			bound_q     <= '0;
			abandoned_q <= 1'b0;
			out_valid_q <= 1'b0;
			r_q         <= '0;
			have_q      <= 1'b0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					if (take) begin
						pos_q  <= t_new + TW'(1);
						r_q    <= '0;
						have_q <= 1'b0;
						if (in_data.first) begin
							bound_q     <= in_data.initial_bound;
							abandoned_q <= 1'b0;
						end
					end
				end
				FSM_SCAN: begin
					r_q <= r_q + AW'(1);
					if (in_win) have_q <= 1'b1;
				end
				FSM_WAIT: begin
					if (drsp.valid) begin
						bound_q     <= bound_out;
						out_valid_q <= 1'b1;
						if (over) abandoned_q <= 1'b1;
					end
				end
				FSM_OUT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						r_q         <= '0;
						have_q      <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			t_q      <= t_new;
			ii_q     <= ii_start;
			ii_end_q <= ii_end;
			cur_x_q  <= in_data.ref_sample;
			cur_uq_q <= in_data.query_env_upper;
			cur_lq_q <= in_data.query_env_lower;
		end
		if (state_q == FSM_SCAN && in_win) begin
			if (!have_q || v0 > up_q) up_q <= v0;
			if (!have_q || v0 < lp_q) lp_q <= v0;
		end
		if (state_q == FSM_WAIT && drsp.valid) begin
			over_q               <= over;
			out_q.position       <= POS_BITS'(ii_q);
			out_q.proj_upper     <= up_q;
			out_q.proj_lower     <= lp_q;
			out_q.dist_incr      <= OUT_LD_BITS'(drsp.ld);
			out_q.running_bound  <= bound_out;
			out_q.status         <= over ? STAT_ABANDONED :
				((ii_q == m_t - TW'(1)) ? STAT_FINISHED : STAT_RUNNING);
			out_q.last           <= over || (ii_q == m_t - TW'(1));
		end
		if (state_q == FSM_OUT && !out_stall && !item_done) ii_q <= ii_q + TW'(1);
		// shift the delay lines once the item is fully handled
		if (push_dl_acc || item_done) begin
			dl_x_q[0]  <= push_dl_acc ? in_data.ref_sample : cur_x_q;
			dl_uq_q[0] <= push_dl_acc ? in_data.query_env_upper : cur_uq_q;
			dl_lq_q[0] <= push_dl_acc ? in_data.query_env_lower : cur_lq_q;
			for (int k = 1; k < W_MAX; k++) begin
				dl_x_q[k]  <= dl_x_q[k-1];
				dl_uq_q[k] <= dl_uq_q[k-1];
				dl_lq_q[k] <= dl_lq_q[k-1];
			end
		end
	end

	assign in_stall  = (state_q != FSM_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// checks
	a_out_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (state_q == FSM_OUT))
		else $error("result valid outside output state");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && out_data.last) |=> (state_q == FSM_IDLE))
		else $error("final result did not end the item");

	a_abandon_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == STAT_ABANDONED) |-> abandoned_q)
		else $error("abandon result without abandon flag");

	a_dist_timing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_ISSUE) |=> ##2 drsp.valid)
		else $error("distance pipeline latency broken");

endmodule
`default_nettype wire
